// ===== rtl/dtu_pkg.sv =====
// Package for the 8080 data-transfer unit: byte and word types, command codes,
// opcode patterns and register codes. It depends on nothing else.
`timescale 1ns / 1ps

package dtu_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [1:0]  cmd_t;
  typedef logic [2:0]  reg_code_t;
  typedef logic [1:0]  pair_code_t;

  // Commands carried with each transaction.
  localparam cmd_t CMD_EXEC  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  // Single-register codes as they appear in the opcode fields.
  localparam reg_code_t REG_B = 3'd0;
  localparam reg_code_t REG_C = 3'd1;
  localparam reg_code_t REG_D = 3'd2;
  localparam reg_code_t REG_E = 3'd3;
  localparam reg_code_t REG_H = 3'd4;
  localparam reg_code_t REG_L = 3'd5;
  localparam reg_code_t REG_M = 3'd6;
  localparam reg_code_t REG_A = 3'd7;

  // Register-pair codes.
  localparam pair_code_t PAIR_BC = 2'd0;
  localparam pair_code_t PAIR_DE = 2'd1;
  localparam pair_code_t PAIR_HL = 2'd2;
  localparam pair_code_t PAIR_SP = 2'd3;

  // Opcode masks and patterns. Every opcode from 0x40 to 0x7f is a MOV.
  localparam byte_t MOV_MASK = 8'hc0;
  localparam byte_t MOV_PAT  = 8'h40;
  localparam byte_t MVI_MASK = 8'hc7;
  localparam byte_t MVI_PAT  = 8'h06;
  localparam byte_t LXI_MASK = 8'hcf;
  localparam byte_t LXI_PAT  = 8'h01;

  localparam byte_t OP_LDA    = 8'h3a;
  localparam byte_t OP_STA    = 8'h32;
  localparam byte_t OP_LHLD   = 8'h2a;
  localparam byte_t OP_SHLD   = 8'h22;
  localparam byte_t OP_LDAX_B = 8'h0a;
  localparam byte_t OP_LDAX_D = 8'h1a;
  localparam byte_t OP_STAX_B = 8'h02;
  localparam byte_t OP_STAX_D = 8'h12;
  localparam byte_t OP_XCHG   = 8'heb;

endpackage

// ===== rtl/dtu_in_if.sv =====
// Input channel of the data-transfer unit: handshake plus command payload.
// Depends on dtu_pkg for the payload types.
`timescale 1ns / 1ps

interface dtu_in_if;
  logic          valid;
  logic          ready;
  dtu_pkg::cmd_t  command;
  dtu_pkg::byte_t opcode;
  dtu_pkg::word_t operand;
  dtu_pkg::byte_t write_byte;

  modport source (output valid, output command, output opcode, output operand,
                  output write_byte, input ready);
  modport sink   (input valid, input command, input opcode, input operand,
                  input write_byte, output ready);
endinterface

// ===== rtl/dtu_out_if.sv =====
// Result channel of the data-transfer unit: handshake plus register snapshot.
// Depends on dtu_pkg for the payload types.
`timescale 1ns / 1ps

interface dtu_out_if;
  logic           valid;
  logic           ready;
  dtu_pkg::byte_t reg_a;
  dtu_pkg::byte_t reg_b;
  dtu_pkg::byte_t reg_c;
  dtu_pkg::byte_t reg_d;
  dtu_pkg::byte_t reg_e;
  dtu_pkg::byte_t reg_h;
  dtu_pkg::byte_t reg_l;
  dtu_pkg::word_t stack_ptr;
  dtu_pkg::byte_t peek_byte;
  logic           handled;

  modport source (output valid, output reg_a, output reg_b, output reg_c,
                  output reg_d, output reg_e, output reg_h, output reg_l,
                  output stack_ptr, output peek_byte, output handled,
                  input ready);
  modport sink   (input valid, input reg_a, input reg_b, input reg_c,
                  input reg_d, input reg_e, input reg_h, input reg_l,
                  input stack_ptr, input peek_byte, input handled,
                  output ready);
endinterface

// ===== rtl/dtu_mem.sv =====
// Single-port synchronous byte memory with a registered read.
// Depends on dtu_pkg for the byte type.
`timescale 1ns / 1ps

module dtu_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  dtu_pkg::byte_t       wdata,
  output dtu_pkg::byte_t       rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  dtu_pkg::byte_t mem_r [DEPTH];
  dtu_pkg::byte_t rdata_r;

  // One access per cycle: either a write or a registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cpu_data_transfer_unit.sv =====
// 8080 data-transfer unit: register file in flip-flops, byte memory in dtu_mem (dtu_pkg).
// Results: register-only, memory-write, MVI M and MOV M,r transactions load the output
// register on acceptance; reads finish in ST_RD_REG or ST_RD_PEEK, SHLD in ST_SHLD_HI,
// LHLD in ST_LHLD_LO then ST_LHLD_HI. One transaction per cycle while results are taken
// and no read, SHLD or LHLD is under way: the single memory port with its registered read.
// Reset (rst_n low, synchronous) clears A..L, SP and the handshake; memory is not cleared.
`timescale 1ns / 1ps

module cpu_data_transfer_unit #(
  parameter int ADDR_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dtu_in_if.sink    in_ch,
  dtu_out_if.source out_ch
);

  // Sequencer states. Idle accepts a new transaction; the others finish the
  // memory accesses of a transaction that has already been accepted.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RD_REG  = 3'd1;  // read data goes to a register
  localparam logic [2:0] ST_RD_PEEK = 3'd2;  // read data goes to peek_byte
  localparam logic [2:0] ST_LHLD_LO = 3'd3;  // low byte arrives, fetch high
  localparam logic [2:0] ST_LHLD_HI = 3'd4;  // high byte arrives
  localparam logic [2:0] ST_SHLD_HI = 3'd5;  // write the high byte of HL

  logic [2:0] state_r, state_nxt;
  dtu_pkg::reg_code_t dst_r, dst_nxt;
  dtu_pkg::word_t     addr_r, addr_nxt;

  // Architectural registers.
  dtu_pkg::byte_t a_r, b_r, c_r, d_r, e_r, h_r, l_r;
  dtu_pkg::byte_t a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, h_nxt, l_nxt;
  dtu_pkg::word_t sp_r, sp_nxt;

  // Output register.
  logic           out_valid_r;
  dtu_pkg::byte_t o_a_r, o_b_r, o_c_r, o_d_r, o_e_r, o_h_r, o_l_r, o_rd_r;
  dtu_pkg::word_t o_sp_r;
  logic           o_hnd_r;

  // Memory port.
  logic           mem_en, mem_we;
  dtu_pkg::word_t mem_addr;
  dtu_pkg::byte_t mem_wdata, mem_rdata;

  // Register update requests: a byte write, a pair write or the XCHG swap.
  logic                bw_en;
  dtu_pkg::reg_code_t  bw_code;
  dtu_pkg::byte_t      bw_val;
  logic                pw_en;
  dtu_pkg::pair_code_t pw_code;
  dtu_pkg::word_t      pw_val;
  logic                swap_en;

  // Completion of a transaction loads the output register.
  logic           done;
  logic           done_hnd;
  dtu_pkg::byte_t done_rd;

  logic               in_fire;
  dtu_pkg::byte_t     op;
  dtu_pkg::reg_code_t src, dst;
  dtu_pkg::byte_t     src_val;
  dtu_pkg::word_t     hl_addr, ldax_addr;

  // A new transaction is taken only while no memory access is outstanding, so
  // the registers it reads are always up to date. The output register frees
  // itself in the same cycle that its result is taken.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign op      = in_ch.opcode;
  assign src     = op[2:0];
  assign dst     = op[5:3];
  assign hl_addr = {h_r, l_r};
  // LDAX and STAX use BC or DE, chosen by bit 4 of the opcode.
  assign ldax_addr = op[4] ? {d_r, e_r} : {b_r, c_r};

  always_comb begin
    case (src)
      dtu_pkg::REG_B: src_val = b_r;
      dtu_pkg::REG_C: src_val = c_r;
      dtu_pkg::REG_D: src_val = d_r;
      dtu_pkg::REG_E: src_val = e_r;
      dtu_pkg::REG_H: src_val = h_r;
      dtu_pkg::REG_L: src_val = l_r;
      dtu_pkg::REG_A: src_val = a_r;
      default:        src_val = a_r;  // memory source is handled by a read
    endcase
  end

  // Sequencer and instruction decode.
  always_comb begin
    state_nxt = state_r;
    dst_nxt   = dst_r;
    addr_nxt  = addr_r;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = hl_addr;
    mem_wdata = a_r;
    bw_en     = 1'b0;
    bw_code   = dtu_pkg::REG_A;
    bw_val    = mem_rdata;
    pw_en     = 1'b0;
    pw_code   = dtu_pkg::PAIR_SP;
    pw_val    = in_ch.operand;
    swap_en   = 1'b0;
    done      = 1'b0;
    done_hnd  = 1'b1;
    done_rd   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.command)
            dtu_pkg::CMD_EXEC: begin
              if ((op & dtu_pkg::MOV_MASK) == dtu_pkg::MOV_PAT) begin
                // MOV. MOV M,M rewrites a byte with itself, so nothing changes.
                if (src == dtu_pkg::REG_M && dst == dtu_pkg::REG_M) begin
                  done = 1'b1;
                end else if (src == dtu_pkg::REG_M) begin
                  mem_en    = 1'b1;
                  dst_nxt   = dst;
                  state_nxt = ST_RD_REG;
                end else if (dst == dtu_pkg::REG_M) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_wdata = src_val;
                  done      = 1'b1;
                end else begin
                  bw_en   = 1'b1;
                  bw_code = dst;
                  bw_val  = src_val;
                  done    = 1'b1;
                end
              end else if ((op & dtu_pkg::MVI_MASK) == dtu_pkg::MVI_PAT) begin
                if (dst == dtu_pkg::REG_M) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_wdata = in_ch.operand[7:0];
                end else begin
                  bw_en   = 1'b1;
                  bw_code = dst;
                  bw_val  = in_ch.operand[7:0];
                end
                done = 1'b1;
              end else if ((op & dtu_pkg::LXI_MASK) == dtu_pkg::LXI_PAT) begin
                pw_en   = 1'b1;
                pw_code = op[5:4];
                done    = 1'b1;
              end else if (op == dtu_pkg::OP_LDA) begin
                mem_en    = 1'b1;
                mem_addr  = in_ch.operand;
                dst_nxt   = dtu_pkg::REG_A;
                state_nxt = ST_RD_REG;
              end else if (op == dtu_pkg::OP_STA) begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = in_ch.operand;
                done     = 1'b1;
              end else if (op == dtu_pkg::OP_LHLD) begin
                mem_en    = 1'b1;
                mem_addr  = in_ch.operand;
                addr_nxt  = in_ch.operand + 16'd1;
                state_nxt = ST_LHLD_LO;
              end else if (op == dtu_pkg::OP_SHLD) begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = in_ch.operand;
                mem_wdata = l_r;
                addr_nxt  = in_ch.operand + 16'd1;
                state_nxt = ST_SHLD_HI;
              end else if (op == dtu_pkg::OP_LDAX_B || op == dtu_pkg::OP_LDAX_D) begin
                mem_en    = 1'b1;
                mem_addr  = ldax_addr;
                dst_nxt   = dtu_pkg::REG_A;
                state_nxt = ST_RD_REG;
              end else if (op == dtu_pkg::OP_STAX_B || op == dtu_pkg::OP_STAX_D) begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = ldax_addr;
                done     = 1'b1;
              end else if (op == dtu_pkg::OP_XCHG) begin
                swap_en = 1'b1;
                done    = 1'b1;
              end else begin
                // Not a data-transfer opcode: registers stay as they are.
                done     = 1'b1;
                done_hnd = 1'b0;
              end
            end
            dtu_pkg::CMD_WRITE: begin
              mem_en    = 1'b1;
              mem_we    = 1'b1;
              mem_addr  = in_ch.operand;
              mem_wdata = in_ch.write_byte;
              done      = 1'b1;
            end
            dtu_pkg::CMD_READ: begin
              mem_en    = 1'b1;
              mem_addr  = in_ch.operand;
              state_nxt = ST_RD_PEEK;
            end
            default: begin
              done     = 1'b1;
              done_hnd = 1'b0;
            end
          endcase
        end
      end
      ST_RD_REG: begin
        bw_en     = 1'b1;
        bw_code   = dst_r;
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RD_PEEK: begin
        done      = 1'b1;
        done_rd   = mem_rdata;
        state_nxt = ST_IDLE;
      end
      ST_LHLD_LO: begin
        // L takes the first byte while the second byte is fetched.
        bw_en     = 1'b1;
        bw_code   = dtu_pkg::REG_L;
        mem_en    = 1'b1;
        mem_addr  = addr_r;
        state_nxt = ST_LHLD_HI;
      end
      ST_LHLD_HI: begin
        bw_en     = 1'b1;
        bw_code   = dtu_pkg::REG_H;
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SHLD_HI: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = addr_r;
        mem_wdata = h_r;
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Apply the register update requests. At most one is active in a cycle.
  always_comb begin
    a_nxt  = a_r;
    b_nxt  = b_r;
    c_nxt  = c_r;
    d_nxt  = d_r;
    e_nxt  = e_r;
    h_nxt  = h_r;
    l_nxt  = l_r;
    sp_nxt = sp_r;
    if (bw_en) begin
      case (bw_code)
        dtu_pkg::REG_B: b_nxt = bw_val;
        dtu_pkg::REG_C: c_nxt = bw_val;
        dtu_pkg::REG_D: d_nxt = bw_val;
        dtu_pkg::REG_E: e_nxt = bw_val;
        dtu_pkg::REG_H: h_nxt = bw_val;
        dtu_pkg::REG_L: l_nxt = bw_val;
        dtu_pkg::REG_A: a_nxt = bw_val;
        default: ;
      endcase
    end
    if (pw_en) begin
      case (pw_code)
        dtu_pkg::PAIR_BC: begin
          b_nxt = pw_val[15:8];
          c_nxt = pw_val[7:0];
        end
        dtu_pkg::PAIR_DE: begin
          d_nxt = pw_val[15:8];
          e_nxt = pw_val[7:0];
        end
        dtu_pkg::PAIR_HL: begin
          h_nxt = pw_val[15:8];
          l_nxt = pw_val[7:0];
        end
        default: sp_nxt = pw_val;
      endcase
    end
    if (swap_en) begin
      d_nxt = h_r;
      e_nxt = l_r;
      h_nxt = d_r;
      l_nxt = e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_r         <= '0;
      b_r         <= '0;
      c_r         <= '0;
      d_r         <= '0;
      e_r         <= '0;
      h_r         <= '0;
      l_r         <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      d_r     <= d_nxt;
      e_r     <= e_nxt;
      h_r     <= h_nxt;
      l_r     <= l_nxt;
      sp_r    <= sp_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    dst_r  <= dst_nxt;
    addr_r <= addr_nxt;
    if (done) begin
      o_a_r   <= a_nxt;
      o_b_r   <= b_nxt;
      o_c_r   <= c_nxt;
      o_d_r   <= d_nxt;
      o_e_r   <= e_nxt;
      o_h_r   <= h_nxt;
      o_l_r   <= l_nxt;
      o_sp_r  <= sp_nxt;
      o_rd_r  <= done_rd;
      o_hnd_r <= done_hnd;
    end
  end

  dtu_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr[ADDR_BITS-1:0]),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.reg_a     = o_a_r;
  assign out_ch.reg_b     = o_b_r;
  assign out_ch.reg_c     = o_c_r;
  assign out_ch.reg_d     = o_d_r;
  assign out_ch.reg_e     = o_e_r;
  assign out_ch.reg_h     = o_h_r;
  assign out_ch.reg_l     = o_l_r;
  assign out_ch.stack_ptr = o_sp_r;
  assign out_ch.peek_byte = o_rd_r;
  assign out_ch.handled   = o_hnd_r;

endmodule

// ===== tb/cpu_data_transfer_unit_tb.sv =====
// Self-checking testbench for the 8080 data-transfer unit (cpu_data_transfer_unit).
// Depends on dtu_pkg, dtu_in_if, dtu_out_if and the RTL of the unit with dtu_mem.
`timescale 1ns / 1ps

module cpu_data_transfer_unit_tb;

  localparam int             ADDR_BITS = 16;
  localparam int             MEM_WORDS = 1 << ADDR_BITS;
  localparam dtu_pkg::word_t ADDR_MASK = dtu_pkg::word_t'(MEM_WORDS - 1);

  // Two single-byte codes outside the transfer group.
  localparam dtu_pkg::byte_t OP_NOP  = 8'h00;
  localparam dtu_pkg::byte_t OP_RST7 = 8'hff;

  // Command code 3 carries no meaning and must leave the unit untouched.
  localparam dtu_pkg::cmd_t CMD_NONE = 2'd3;

  localparam int TOTAL_ITEMS  = 1250;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    dtu_pkg::cmd_t  command;
    dtu_pkg::byte_t opcode;
    dtu_pkg::word_t operand;
    dtu_pkg::byte_t write_byte;
  } xfer_item_t;

  typedef struct packed {
    dtu_pkg::byte_t reg_a;
    dtu_pkg::byte_t reg_b;
    dtu_pkg::byte_t reg_c;
    dtu_pkg::byte_t reg_d;
    dtu_pkg::byte_t reg_e;
    dtu_pkg::byte_t reg_h;
    dtu_pkg::byte_t reg_l;
    dtu_pkg::word_t stack_ptr;
    dtu_pkg::byte_t peek_byte;
    logic           handled;
  } reg_snapshot_t;

  // Mirror of the register file and memory. Each accepted transaction is
  // applied to the mirror and the resulting register snapshot is queued;
  // each result from the unit is checked against the oldest snapshot.
  class transfer_scoreboard;
    dtu_pkg::byte_t acc;
    dtu_pkg::byte_t gp[6];
    dtu_pkg::word_t sp;
    dtu_pkg::byte_t mem[MEM_WORDS];
    bit    written[MEM_WORDS];
    dtu_pkg::word_t written_list[$];
    reg_snapshot_t expected_snapshots[$];
    int    error_count;
    int    items_noted;
    int    handled_count;
    int    reads_noted;
    int    results_seen;

    function new();
      acc = '0;
      foreach (gp[i]) gp[i] = '0;
      sp = '0;
      error_count = 0;
      items_noted = 0;
      handled_count = 0;
      reads_noted = 0;
      results_seen = 0;
    endfunction

    function dtu_pkg::word_t hl();
      return {gp[dtu_pkg::REG_H], gp[dtu_pkg::REG_L]};
    endfunction

    function dtu_pkg::byte_t mem_rd(dtu_pkg::word_t addr);
      return written[addr & ADDR_MASK] ? mem[addr & ADDR_MASK] : 8'h00;
    endfunction

    function void mem_wr(dtu_pkg::word_t addr, dtu_pkg::byte_t value);
      if (!written[addr & ADDR_MASK]) written_list.push_back(addr & ADDR_MASK);
      written[addr & ADDR_MASK] = 1'b1;
      mem[addr & ADDR_MASK] = value;
    endfunction

    function dtu_pkg::byte_t reg_rd(dtu_pkg::reg_code_t code);
      if (code == dtu_pkg::REG_A) return acc;
      if (code == dtu_pkg::REG_M) return mem_rd(hl());
      return gp[code];
    endfunction

    function void reg_wr(dtu_pkg::reg_code_t code, dtu_pkg::byte_t value);
      if (code == dtu_pkg::REG_A) acc = value;
      else if (code == dtu_pkg::REG_M) mem_wr(hl(), value);
      else gp[code] = value;
    endfunction

    function dtu_pkg::word_t pair_rd(dtu_pkg::pair_code_t code);
      if (code == dtu_pkg::PAIR_SP) return sp;
      return {gp[2 * code], gp[2 * code + 1]};
    endfunction

    function void pair_wr(dtu_pkg::pair_code_t code, dtu_pkg::word_t value);
      if (code == dtu_pkg::PAIR_SP) sp = value;
      else begin
        gp[2 * code]     = value[15:8];
        gp[2 * code + 1] = value[7:0];
      end
    endfunction

    // Executes one instruction on the mirror; returns 0 for opcodes outside
    // the data-transfer group, which leave everything unchanged.
    function bit run_transfer(dtu_pkg::byte_t op, dtu_pkg::word_t imm);
      dtu_pkg::word_t next;
      dtu_pkg::byte_t swap;
      next = imm + 16'd1;
      if ((op & dtu_pkg::MOV_MASK) == dtu_pkg::MOV_PAT) reg_wr(op[5:3], reg_rd(op[2:0]));
      else if ((op & dtu_pkg::MVI_MASK) == dtu_pkg::MVI_PAT) reg_wr(op[5:3], imm[7:0]);
      else if ((op & dtu_pkg::LXI_MASK) == dtu_pkg::LXI_PAT) pair_wr(op[5:4], imm);
      else if (op == dtu_pkg::OP_LDA) acc = mem_rd(imm);
      else if (op == dtu_pkg::OP_STA) mem_wr(imm, acc);
      else if (op == dtu_pkg::OP_LHLD) begin
        gp[dtu_pkg::REG_L] = mem_rd(imm);
        gp[dtu_pkg::REG_H] = mem_rd(next);
      end else if (op == dtu_pkg::OP_SHLD) begin
        mem_wr(imm, gp[dtu_pkg::REG_L]);
        mem_wr(next, gp[dtu_pkg::REG_H]);
      end else if (op == dtu_pkg::OP_LDAX_B || op == dtu_pkg::OP_LDAX_D)
        acc = mem_rd(pair_rd(op[5:4]));
      else if (op == dtu_pkg::OP_STAX_B || op == dtu_pkg::OP_STAX_D)
        mem_wr(pair_rd(op[5:4]), acc);
      else if (op == dtu_pkg::OP_XCHG) begin
        swap = gp[dtu_pkg::REG_H];
        gp[dtu_pkg::REG_H] = gp[dtu_pkg::REG_D];
        gp[dtu_pkg::REG_D] = swap;
        swap = gp[dtu_pkg::REG_L];
        gp[dtu_pkg::REG_L] = gp[dtu_pkg::REG_E];
        gp[dtu_pkg::REG_E] = swap;
      end else return 1'b0;
      return 1'b1;
    endfunction

    // Finds the first memory byte the transaction would read that was never
    // written; such reads have no defined answer and must not be issued.
    function bit needs_unwritten(xfer_item_t it, output dtu_pkg::word_t addr);
      dtu_pkg::word_t reads[$];
      if (it.command == dtu_pkg::CMD_READ) reads.push_back(it.operand);
      else if (it.command == dtu_pkg::CMD_EXEC) begin
        if ((it.opcode & dtu_pkg::MOV_MASK) == dtu_pkg::MOV_PAT &&
            it.opcode[2:0] == dtu_pkg::REG_M)
          reads.push_back(hl());
        else if (it.opcode == dtu_pkg::OP_LDA) reads.push_back(it.operand);
        else if (it.opcode == dtu_pkg::OP_LHLD) begin
          reads.push_back(it.operand);
          reads.push_back(it.operand + 16'd1);
        end else if (it.opcode == dtu_pkg::OP_LDAX_B || it.opcode == dtu_pkg::OP_LDAX_D)
          reads.push_back(pair_rd(it.opcode[5:4]));
      end
      foreach (reads[i]) begin
        if (!written[reads[i] & ADDR_MASK]) begin
          addr = reads[i];
          return 1'b1;
        end
      end
      addr = '0;
      return 1'b0;
    endfunction

    function void note_input(xfer_item_t it);
      reg_snapshot_t snap;
      bit ok;
      ok = 1'b0;
      snap.peek_byte = 8'h00;
      if (it.command == dtu_pkg::CMD_EXEC) ok = run_transfer(it.opcode, it.operand);
      else if (it.command == dtu_pkg::CMD_WRITE) begin
        mem_wr(it.operand, it.write_byte);
        ok = 1'b1;
      end else if (it.command == dtu_pkg::CMD_READ) begin
        snap.peek_byte = mem_rd(it.operand);
        ok = 1'b1;
        reads_noted++;
      end
      snap.reg_a = acc;
      snap.reg_b = gp[dtu_pkg::REG_B];
      snap.reg_c = gp[dtu_pkg::REG_C];
      snap.reg_d = gp[dtu_pkg::REG_D];
      snap.reg_e = gp[dtu_pkg::REG_E];
      snap.reg_h = gp[dtu_pkg::REG_H];
      snap.reg_l = gp[dtu_pkg::REG_L];
      snap.stack_ptr = sp;
      snap.handled = ok;
      expected_snapshots.push_back(snap);
      items_noted++;
      if (ok) handled_count++;
    endfunction

    function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp, act);
        error_count++;
      end
    endfunction

    function void check_result(reg_snapshot_t got);
      reg_snapshot_t exp;
      results_seen++;
      if (expected_snapshots.size() == 0) begin
        $error("result transaction arrived with no expected snapshot pending");
        error_count++;
        return;
      end
      exp = expected_snapshots.pop_front();
      compare_field("reg_a", exp.reg_a, got.reg_a);
      compare_field("reg_b", exp.reg_b, got.reg_b);
      compare_field("reg_c", exp.reg_c, got.reg_c);
      compare_field("reg_d", exp.reg_d, got.reg_d);
      compare_field("reg_e", exp.reg_e, got.reg_e);
      compare_field("reg_h", exp.reg_h, got.reg_h);
      compare_field("reg_l", exp.reg_l, got.reg_l);
      compare_field("stack_ptr", exp.stack_ptr, got.stack_ptr);
      compare_field("peek_byte", exp.peek_byte, got.peek_byte);
      compare_field("handled", exp.handled, got.handled);
    endfunction

    function int pending();
      return expected_snapshots.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;

  dtu_in_if  in_ch();
  dtu_out_if out_ch();

  transfer_scoreboard sb = new();

  cpu_data_transfer_unit #(.ADDR_BITS(ADDR_BITS)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length for either side: mostly none or a short gap, now and then a
  // long pause. During calm stretches neither side idles at all.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic dtu_pkg::byte_t mov_op(dtu_pkg::reg_code_t dst, dtu_pkg::reg_code_t src);
    return dtu_pkg::MOV_PAT | {2'b00, dst, src};
  endfunction

  function automatic dtu_pkg::byte_t mvi_op(dtu_pkg::reg_code_t dst);
    return dtu_pkg::MVI_PAT | {2'b00, dst, 3'b000};
  endfunction

  function automatic dtu_pkg::byte_t lxi_op(dtu_pkg::pair_code_t pair);
    return dtu_pkg::LXI_PAT | {2'b00, pair, 4'b0000};
  endfunction

  // Fields that a command ignores still get random values so that every
  // payload bit toggles.
  function automatic xfer_item_t exec_item(dtu_pkg::byte_t op, dtu_pkg::word_t imm);
    xfer_item_t it;
    it.command = dtu_pkg::CMD_EXEC;
    it.opcode = op;
    it.operand = imm;
    it.write_byte = dtu_pkg::byte_t'($urandom);
    return it;
  endfunction

  function automatic xfer_item_t mem_item(dtu_pkg::cmd_t cmd, dtu_pkg::word_t addr,
                                          dtu_pkg::byte_t data);
    xfer_item_t it;
    it.command = cmd;
    it.opcode = dtu_pkg::byte_t'($urandom);
    it.operand = addr;
    it.write_byte = data;
    return it;
  endfunction

  // An address that already holds data, so that loads have something to read.
  function automatic dtu_pkg::word_t pick_written();
    if (sb.written_list.size() == 0) return dtu_pkg::word_t'($urandom);
    return sb.written_list[$urandom_range(0, sb.written_list.size() - 1)];
  endfunction

  function automatic dtu_pkg::word_t some_addr(int written_pct);
    if ($urandom_range(0, 99) < written_pct) return pick_written();
    return dtu_pkg::word_t'($urandom);
  endfunction

  // One random transaction. The mix favors real instructions whose pointers
  // and addresses land on memory that holds data; the remainder is noise
  // (undecoded opcodes and the meaningless command).
  function automatic xfer_item_t random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return mem_item(dtu_pkg::CMD_WRITE, some_addr(50),
                                dtu_pkg::byte_t'($urandom));
    if (r < 24) return mem_item(dtu_pkg::CMD_READ, pick_written(),
                                dtu_pkg::byte_t'($urandom));
    if (r < 46) return exec_item(mov_op(dtu_pkg::reg_code_t'($urandom),
                                        dtu_pkg::reg_code_t'($urandom)),
                                 dtu_pkg::word_t'($urandom));
    if (r < 55) return exec_item(mvi_op(dtu_pkg::reg_code_t'($urandom)),
                                 dtu_pkg::word_t'($urandom));
    if (r < 65) return exec_item(lxi_op(dtu_pkg::pair_code_t'($urandom)), some_addr(60));
    if (r < 70) return exec_item(dtu_pkg::OP_LDA, some_addr(70));
    if (r < 75) return exec_item(dtu_pkg::OP_STA, some_addr(40));
    if (r < 79) return exec_item(dtu_pkg::OP_LHLD, some_addr(70));
    if (r < 83) return exec_item(dtu_pkg::OP_SHLD, some_addr(40));
    if (r < 88) return exec_item($urandom_range(0, 1) ? dtu_pkg::OP_LDAX_D : dtu_pkg::OP_LDAX_B,
                                 dtu_pkg::word_t'($urandom));
    if (r < 92) return exec_item($urandom_range(0, 1) ? dtu_pkg::OP_STAX_D : dtu_pkg::OP_STAX_B,
                                 dtu_pkg::word_t'($urandom));
    if (r < 95) return exec_item(dtu_pkg::OP_XCHG, dtu_pkg::word_t'($urandom));
    if (r < 98) return exec_item(dtu_pkg::byte_t'($urandom), dtu_pkg::word_t'($urandom));
    return mem_item(CMD_NONE, dtu_pkg::word_t'($urandom), dtu_pkg::byte_t'($urandom));
  endfunction

  // Drives one transaction starting at a falling edge and returns at the
  // falling edge after it was accepted. The accepted transaction is noted at
  // the rising edge where valid and ready were both high.
  task automatic send_item(input xfer_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= it.command;
    in_ch.opcode     <= it.opcode;
    in_ch.operand    <= it.operand;
    in_ch.write_byte <= it.write_byte;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Before any transaction that would read a never-written byte, that byte
  // is filled by a memory-write transaction with random data.
  task automatic issue(input xfer_item_t it);
    xfer_item_t fill;
    dtu_pkg::word_t addr;
    while (sb.needs_unwritten(it, addr)) begin
      fill = mem_item(dtu_pkg::CMD_WRITE, addr, dtu_pkg::byte_t'($urandom));
      send_item(fill);
    end
    send_item(it);
  endtask

  // Result side: ready stalls at random, with calm stretches held high.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rst_n !== 1'b1) out_ch.ready <= 1'b0;
      else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  // Results are sampled at the rising edge where the handshake completes.
  always @(posedge clk) begin
    reg_snapshot_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.reg_a = out_ch.reg_a;
      got.reg_b = out_ch.reg_b;
      got.reg_c = out_ch.reg_c;
      got.reg_d = out_ch.reg_d;
      got.reg_e = out_ch.reg_e;
      got.reg_h = out_ch.reg_h;
      got.reg_l = out_ch.reg_l;
      got.stack_ptr = out_ch.stack_ptr;
      got.peek_byte = out_ch.peek_byte;
      got.handled = out_ch.handled;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = dtu_pkg::CMD_EXEC;
    in_ch.opcode = OP_NOP;
    in_ch.operand = '0;
    in_ch.write_byte = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: address extremes, every instruction form, wrap of the
    // second LHLD/SHLD address at the top of memory, MOV M,M, undecoded
    // opcodes and the meaningless command.
    issue(mem_item(dtu_pkg::CMD_WRITE, 16'h0000, 8'h00));
    issue(mem_item(dtu_pkg::CMD_WRITE, 16'hffff, 8'hff));
    issue(mem_item(dtu_pkg::CMD_READ, 16'hffff, 8'h00));
    issue(mem_item(dtu_pkg::CMD_READ, 16'h0000, 8'hff));
    issue(exec_item(lxi_op(dtu_pkg::PAIR_BC), 16'h1234));
    issue(exec_item(lxi_op(dtu_pkg::PAIR_DE), 16'hffff));
    issue(exec_item(lxi_op(dtu_pkg::PAIR_HL), 16'h0000));
    issue(exec_item(lxi_op(dtu_pkg::PAIR_SP), 16'hffff));
    issue(exec_item(mvi_op(dtu_pkg::REG_A), 16'h00ff));
    issue(exec_item(mvi_op(dtu_pkg::REG_M), 16'hffa5));
    issue(exec_item(mov_op(dtu_pkg::REG_B, dtu_pkg::REG_M), 16'h0000));
    issue(exec_item(mov_op(dtu_pkg::REG_M, dtu_pkg::REG_A), 16'h0000));
    issue(exec_item(mov_op(dtu_pkg::REG_M, dtu_pkg::REG_M), 16'h0000));
    issue(exec_item(mov_op(dtu_pkg::REG_A, dtu_pkg::REG_B), 16'h0000));
    issue(exec_item(dtu_pkg::OP_STA, 16'h8000));
    issue(exec_item(dtu_pkg::OP_LDA, 16'h8000));
    issue(exec_item(dtu_pkg::OP_SHLD, 16'hffff));
    issue(exec_item(dtu_pkg::OP_LHLD, 16'hffff));
    issue(exec_item(dtu_pkg::OP_STAX_B, 16'h0000));
    issue(exec_item(dtu_pkg::OP_LDAX_B, 16'h0000));
    issue(exec_item(dtu_pkg::OP_STAX_D, 16'h0000));
    issue(exec_item(dtu_pkg::OP_LDAX_D, 16'h0000));
    issue(exec_item(dtu_pkg::OP_XCHG, 16'h0000));
    issue(exec_item(OP_NOP, 16'hffff));
    issue(exec_item(OP_RST7, 16'h0000));
    issue(mem_item(CMD_NONE, 16'hffff, 8'hff));

    // Random part, up to the total transaction count. The last fifth of
    // every 300 transactions runs without idling.
    while (sb.items_noted < TOTAL_ITEMS) begin
      calm = (sb.items_noted % 300) >= 240;
      issue(random_item());
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain: wait for every expected snapshot, then wait out DRAIN_CYCLES as well
    // so that a stray extra result would still be caught.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d transactions sent (%0d handled, %0d memory reads),",
             sb.items_noted, sb.handled_count, sb.reads_noted);
    $display("%0d results checked, %0d memory bytes touched, %0d mismatches.",
             sb.results_seen, sb.written_list.size(), sb.error_count);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with the longest idles.
  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d expected snapshots still pending.", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
